FILE: design/virtqueue_tx_descriptor_manager_defines.svh
// assertion macros for the transmit descriptor manager checks
`ifndef VIRTQUEUE_TX_DESCRIPTOR_MANAGER_DEFINES_SVH
`define VIRTQUEUE_TX_DESCRIPTOR_MANAGER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VQTX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vqtx check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VQTX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vqtx check failed");

`endif

FILE: design/vqtx_pkg.sv
// shared types and constants of the transmit descriptor manager
`default_nettype none

package vqtx_pkg;

  localparam int RING_SIZE     = 256;
  localparam int IDX_W         = $clog2(RING_SIZE);
  localparam int CNT_W         = $clog2(RING_SIZE) + 1;
  localparam int ADDR_W        = 64;
  localparam int LEN_W         = 16;
  localparam int DESC_PER_SEND = 2;

  // stream word layouts
  localparam int S_TDATA_W = ((ADDR_W + LEN_W + 8 + 7) / 8) * 8;
  localparam int M_FIELDS_W = 8 + 8 + 8 + ADDR_W + LEN_W + 9 + 9;
  localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_CPL  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_SENT   = 2'd0,
    ST_REJECT = 2'd1,
    ST_DONE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND_RD,
    S_SEND_LINK,
    S_SEND_FIN,
    S_CPL_RD,
    S_CPL_CHK
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic send_rd;
    logic send_link;
    logic send_fin;
    logic rej_fin;
    logic cpl_rd;
    logic cpl_step;
    logic cpl_fin;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_kind;
    logic few;
    logic chain_more;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/virtqueue_tx_descriptor_manager.sv
// top level of the transmit split-virtqueue descriptor free-list manager
//
//  channel   dir  tuser          tdata (from bit 0)
//  s_axis    in   kind           data_address, data_length, completed_head
//  m_axis    out  status         head_index, payload_index, ring_slot,
//                                payload_address, payload_length,
//                                freed_count, free_count
//
// send: accept, head read, link read, finish, in that order
// rejected send: accept, then finish; completion: accept, head read, one read per further chained descriptor, finish
// the steps follow from the single link memory with a registered read port,
// one dependent read per cycle while a chain is followed
// reset: per-entry valid bits give the reset links at once, no clearing pass
// a pending result stalls only the finishing step; the next word waits until that step is done
`default_nettype none

module virtqueue_tx_descriptor_manager (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // bit 0: kind
  input  logic                            s_axis_tuser,
  // data_address[63:0], data_length[79:64], completed_head[87:80]
  input  logic [vqtx_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0]
  output logic [1:0]                      m_axis_tuser,
  // head_index[7:0], payload_index[15:8], ring_slot[23:16],
  // payload_address[87:24], payload_length[103:88], freed_count[112:104],
  // free_count[121:113], zero fill above
  output logic [vqtx_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import vqtx_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: one word at a time, ready only between words
  vqtx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // link memory, free list and the result register
  vqtx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_kind_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: design/vqtx_ctrl.sv
// sequencing state machine of the transmit descriptor manager
`default_nettype none

module vqtx_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vqtx_pkg::dp_stat_t   stat_i,
  output vqtx_pkg::ctrl_cmd_t  cmd_o
);
  import vqtx_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (stat_i.in_kind == KIND_CPL) ? S_CPL_RD : S_SEND_RD;
        end
      end
      S_SEND_RD: begin
        if (!stat_i.few) begin
          state_d = S_SEND_LINK;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SEND_LINK: state_d = S_SEND_FIN;
      S_SEND_FIN: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CPL_RD: state_d = S_CPL_CHK;
      S_CPL_CHK: begin
        if (!stat_i.chain_more && stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SEND_RD: begin
        cmd_o.send_rd = !stat_i.few;
        cmd_o.rej_fin = stat_i.few && stat_i.out_free;
      end
      S_SEND_LINK: cmd_o.send_link = 1'b1;
      S_SEND_FIN:  cmd_o.send_fin = stat_i.out_free;
      S_CPL_RD:    cmd_o.cpl_rd = 1'b1;
      S_CPL_CHK: begin
        cmd_o.cpl_step = stat_i.chain_more;
        cmd_o.cpl_fin  = !stat_i.chain_more && stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/vqtx_dp.sv
// link memory, free-list registers and result register
`default_nettype none

module vqtx_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_kind_i,
  input  logic [vqtx_pkg::S_TDATA_W-1:0]  in_data_i,
  input  vqtx_pkg::ctrl_cmd_t             cmd_i,
  output vqtx_pkg::dp_stat_t              stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vqtx_pkg::M_TDATA_W-1:0]  out_data_o,
  output logic [1:0]                      out_user_o
);
  import vqtx_pkg::*;

  localparam int WORD_W = IDX_W + 1;

  // latched input word
  logic [ADDR_W-1:0] in_addr_q;
  logic [LEN_W-1:0]  in_len_q;
  logic [IDX_W-1:0]  in_head_q;

  // free-list state
  logic [IDX_W-1:0] free_head_q;
  logic [CNT_W-1:0] free_total_q;
  logic [IDX_W-1:0] avail_q;
  logic [CNT_W-1:0] count_q;

  // link memory: {chain flag, next index}, with per-entry valid bits
  logic [WORD_W-1:0]    mem_q [RING_SIZE];
  logic [RING_SIZE-1:0] vld_q;
  logic [WORD_W-1:0]    rd_word_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_addr_q;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;
  logic                 word_flag;
  logic [IDX_W-1:0]     word_link;

  // result register
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  status_e              out_user_q, out_user_d;
  logic                 fin;
  logic [CNT_W:0]       cpl_sum;
  logic [CNT_W-1:0]     cpl_total;
  logic [CNT_W-1:0]     send_total;

  // an entry never written holds its reset link, i+1, and no chain flag
  assign word_flag = rd_vld_q ? rd_word_q[IDX_W] : 1'b0;
  assign word_link = rd_vld_q ? rd_word_q[IDX_W-1:0] : rd_addr_q + IDX_W'(1);

  always_comb begin
    rd_en   = cmd_i.send_rd | cmd_i.send_link | cmd_i.cpl_rd | cmd_i.cpl_step;
    rd_addr = word_link;
    if (cmd_i.send_rd) begin
      rd_addr = free_head_q;
    end else if (cmd_i.cpl_rd) begin
      rd_addr = in_head_q;
    end
  end

  // writes always land on the entry read last
  always_comb begin
    wr_en   = cmd_i.send_link | cmd_i.send_fin | cmd_i.cpl_fin;
    wr_data = {word_flag, free_head_q};
    if (cmd_i.send_link) begin
      wr_data = {1'b1, word_link};
    end else if (cmd_i.send_fin) begin
      wr_data = {1'b0, word_link};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[rd_addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_word_q <= mem_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[rd_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_addr_q <= in_data_i[ADDR_W-1:0];
      in_len_q  <= in_data_i[ADDR_W +: LEN_W];
      in_head_q <= in_data_i[ADDR_W + LEN_W +: IDX_W];
    end
    if (cmd_i.cpl_rd) begin
      count_q <= CNT_W'(1);
    end else if (cmd_i.cpl_step) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  assign send_total = free_total_q - CNT_W'(DESC_PER_SEND);
  assign cpl_sum    = {1'b0, free_total_q} + {1'b0, count_q};
  assign cpl_total  = (cpl_sum > (CNT_W + 1)'(RING_SIZE)) ? CNT_W'(RING_SIZE)
                                                           : cpl_sum[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      free_total_q <= CNT_W'(RING_SIZE);
      avail_q      <= '0;
    end else if (cmd_i.send_fin) begin
      free_head_q  <= word_link;
      free_total_q <= send_total;
      avail_q      <= avail_q + IDX_W'(1);
    end else if (cmd_i.cpl_fin) begin
      free_head_q  <= in_head_q;
      free_total_q <= cpl_total;
    end
  end

  // result word, fields from bit 0: head, payload index, slot, address,
  // length, freed count, free count
  always_comb begin
    out_data_d = '0;
    out_user_d = ST_REJECT;
    out_data_d[121:113] = free_total_q;
    if (cmd_i.send_fin) begin
      out_user_d          = ST_SENT;
      out_data_d[7:0]     = free_head_q;
      out_data_d[15:8]    = rd_addr_q;
      out_data_d[23:16]   = avail_q;
      out_data_d[87:24]   = in_addr_q;
      out_data_d[103:88]  = in_len_q;
      out_data_d[121:113] = send_total;
    end else if (cmd_i.cpl_fin) begin
      out_user_d          = ST_DONE;
      out_data_d[7:0]     = in_head_q;
      out_data_d[112:104] = count_q;
      out_data_d[121:113] = cpl_total;
    end
  end

  assign fin = cmd_i.send_fin | cmd_i.rej_fin | cmd_i.cpl_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign stat_o.in_kind    = in_kind_i;
  assign stat_o.few        = free_total_q <= CNT_W'(DESC_PER_SEND);
  assign stat_o.chain_more = word_flag && (count_q != CNT_W'(RING_SIZE));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

`default_nettype wire

FILE: design/vqtx_checker.sv
// port-level checks of the transmit descriptor manager, bound to the top level
`default_nettype none

`include "virtqueue_tx_descriptor_manager_defines.svh"

module vqtx_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [1:0]                      m_axis_tuser,
  input  logic [vqtx_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import vqtx_pkg::*;

  // result word pieces
  logic                   is_reject;
  logic                   is_done;
  logic                   out_stall;
  logic [CNT_W-1:0]       freed_cnt;
  logic [CNT_W-1:0]       free_cnt;
  logic [M_TDATA_W+1:0]   out_word;

  assign is_reject = m_axis_tvalid && (m_axis_tuser == ST_REJECT);
  assign is_done   = m_axis_tvalid && (m_axis_tuser == ST_DONE);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign freed_cnt = m_axis_tdata[112:104];
  assign free_cnt  = m_axis_tdata[121:113];
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // one word in flight: the cycle after an accept takes no new word
  `VQTX_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a rejected send only happens with two or fewer free descriptors
  `VQTX_ASSERT_IMP(a_reject_few, is_reject, free_cnt <= CNT_W'(DESC_PER_SEND))

  // a completion frees at least its head and the count stays within the ring
  `VQTX_ASSERT_IMP(a_done_counts, is_done, (freed_cnt != '0) && (free_cnt <= CNT_W'(RING_SIZE)))

  // a stalled result holds
  `VQTX_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind virtqueue_tx_descriptor_manager vqtx_checker u_vqtx_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for the transmit descriptor free-list manager
`timescale 1ns / 1ps

module testbench;
  import vqtx_pkg::*;

  // run shape
  localparam int ITEMS_PER_PHASE = 288;  // four phases, about 1150 random words
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int STALL_LIMIT     = 4000; // cycles with no word moving on either side
  localparam int DRAIN_CYCLES    = 40;   // settle time after the last result
  localparam int NOISE_PCT       = 6;    // completions naming an arbitrary head
  localparam int PRINT_CAP       = 50;

  // one input word
  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [IDX_W-1:0]   head;
  } request_t;

  // one result word
  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   head_idx;
    logic [IDX_W-1:0]   payload_idx;
    logic [IDX_W-1:0]   slot;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [CNT_W-1:0]   freed;
    logic [CNT_W-1:0]   free_left;
  } result_t;

  // directed stimulus row, with the result typed in where it is obvious
  typedef struct packed {
    request_t rq;
    logic     known;
    result_t  res;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic                  s_axis_tuser = 1'b0;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [1:0]            m_axis_tuser;
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  // free-list shadow, advanced once per accepted input word
  logic [IDX_W-1:0]  link_tbl [RING_SIZE];
  logic              chained  [RING_SIZE];
  logic [IDX_W-1:0]  fl_head;
  int unsigned       free_cnt;
  logic [15:0]       avail_idx;
  logic [15:0]       used_idx;

  result_t           pending_results [$];  // results still owed by the block
  logic [IDX_W-1:0]  busy_heads [$];       // chain heads handed out, not yet completed
  stim_row_t         directed [$];

  // word currently offered on the input side
  request_t          offer_rq;
  logic              offer_known;
  result_t           offer_res;

  int                mismatches = 0;
  int                quiet_cycles = 0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  int                hold_requests = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  logic              filling = 1'b1;

  virtqueue_tx_descriptor_manager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // expected result of one word; updates the shadow free list
  function automatic result_t predict_free_list(request_t rq);
    result_t           r;
    logic [IDX_W-1:0]  hd;
    logic [IDX_W-1:0]  dt;
    logic [IDX_W-1:0]  cur;
    int unsigned       steps;
    r = '0;
    if (rq.kind == KIND_SEND) begin
      if (free_cnt <= DESC_PER_SEND) begin
        // too few free: nothing changes
        r.status    = ST_REJECT;
        r.free_left = CNT_W'(free_cnt);
      end else begin
        hd = fl_head;
        dt = link_tbl[hd];
        chained[hd]  = 1'b1;
        link_tbl[hd] = dt;
        chained[dt]  = 1'b0;
        fl_head      = link_tbl[dt];
        free_cnt     = free_cnt - DESC_PER_SEND;
        r.status      = ST_SENT;
        r.head_idx    = hd;
        r.payload_idx = dt;
        r.slot        = avail_idx[IDX_W-1:0];
        r.addr        = rq.addr;
        r.len         = rq.len;
        r.free_left   = CNT_W'(free_cnt);
        avail_idx     = avail_idx + 16'd1;
      end
    end else begin
      // follow chain flags to the tail, bounded by the ring size
      cur   = rq.head;
      steps = 1;
      while (chained[cur] && steps < RING_SIZE) begin
        cur   = link_tbl[cur];
        steps = steps + 1;
      end
      link_tbl[cur] = fl_head;
      fl_head       = rq.head;
      free_cnt      = free_cnt + steps;
      if (free_cnt > RING_SIZE) free_cnt = RING_SIZE;
      used_idx      = used_idx + 16'd1;
      r.status    = ST_DONE;
      r.head_idx  = rq.head;
      r.freed     = CNT_W'(steps);
      r.free_left = CNT_W'(free_cnt);
    end
    return r;
  endfunction

  function automatic stim_row_t plain_row(kind_e k, logic [ADDR_W-1:0] a,
                                          logic [LEN_W-1:0] l, logic [IDX_W-1:0] h);
    stim_row_t row;
    row         = '0;
    row.rq.kind = k;
    row.rq.addr = a;
    row.rq.len  = l;
    row.rq.head = h;
    return row;
  endfunction

  function automatic stim_row_t known_row(stim_row_t row, status_e st,
                                          logic [IDX_W-1:0] hi, logic [IDX_W-1:0] pi,
                                          logic [IDX_W-1:0] sl, logic [CNT_W-1:0] fr,
                                          logic [CNT_W-1:0] fc);
    row.known           = 1'b1;
    row.res.status      = st;
    row.res.head_idx    = hi;
    row.res.payload_idx = pi;
    row.res.slot        = sl;
    row.res.addr        = (st == ST_SENT) ? row.rq.addr : '0;
    row.res.len         = (st == ST_SENT) ? row.rq.len : '0;
    row.res.freed       = fr;
    row.res.free_left   = fc;
    return row;
  endfunction

  // random word: well-formed fill and drain swings with a little noise
  function automatic request_t pick_random_request();
    request_t rq;
    int       send_pct;
    rq.addr = {$urandom, $urandom};
    rq.len  = LEN_W'($urandom_range(65535));
    case ($urandom_range(19))
      0: rq.addr = '0;
      1: rq.addr = '1;
      2: rq.len  = '0;
      3: rq.len  = '1;
      default: ;
    endcase
    // switch to draining once the ring is nearly exhausted
    if (filling && free_cnt <= DESC_PER_SEND && $urandom_range(3) == 0) filling = 1'b0;
    if (!filling && busy_heads.size() == 0) filling = 1'b1;
    send_pct = filling ? 85 : 20;
    rq.kind  = ($urandom_range(99) < send_pct) ? KIND_SEND : KIND_CPL;
    if (busy_heads.size() != 0 && $urandom_range(99) >= NOISE_PCT)
      rq.head = busy_heads[$urandom_range(busy_heads.size() - 1)];
    else
      rq.head = IDX_W'($urandom_range(RING_SIZE - 1));
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.status != want.status)           report_mismatch("status", got.status, want.status);
    if (got.head_idx != want.head_idx)       report_mismatch("head_index", got.head_idx,
                                                             want.head_idx);
    if (got.payload_idx != want.payload_idx) report_mismatch("payload_index", got.payload_idx,
                                                             want.payload_idx);
    if (got.slot != want.slot)               report_mismatch("ring_slot", got.slot, want.slot);
    if (got.addr != want.addr)               report_mismatch("payload_address", got.addr,
                                                             want.addr);
    if (got.len != want.len)                 report_mismatch("payload_length", got.len,
                                                             want.len);
    if (got.freed != want.freed)             report_mismatch("freed_count", got.freed,
                                                             want.freed);
    if (got.free_left != want.free_left)     report_mismatch("free_count", got.free_left,
                                                             want.free_left);
  endtask

  // offer one word from a falling edge on, with random sender gaps first
  task automatic offer_word(input request_t rq, input logic known, input result_t res);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    offer_rq      = rq;
    offer_known   = known;
    offer_res     = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.kind;
    s_axis_tdata  <= S_TDATA_W'({rq.head, rq.len, rq.addr});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // monitor: predict on input words, check output words, watch for a hang
  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    result_t predicted;
    int      k;
    logic    found;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = predict_free_list(offer_rq);
        want      = offer_known ? offer_res : predicted;
        pending_results.push_back(want);
        // keep the list of handed-out chain heads in step
        if (predicted.status == ST_SENT) begin
          busy_heads.push_back(predicted.head_idx);
        end else if (predicted.status == ST_DONE) begin
          found = 1'b0;
          for (k = 0; k < busy_heads.size() && !found; k++) begin
            if (busy_heads[k] == predicted.head_idx) begin
              busy_heads.delete(k);
              found = 1'b1;
            end
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status      = status_e'(m_axis_tuser);
        got.head_idx    = m_axis_tdata[7:0];
        got.payload_idx = m_axis_tdata[15:8];
        got.slot        = m_axis_tdata[23:16];
        got.addr        = m_axis_tdata[87:24];
        got.len         = m_axis_tdata[103:88];
        got.freed       = m_axis_tdata[112:104];
        got.free_left   = m_axis_tdata[121:113];
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending", got.head_idx, '0);
        end else begin
          want = pending_results.pop_front();
          check_result(got, want);
        end
      end
      // watchdog on cycles where no word moves
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("virtqueue_tx_descriptor_manager verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    int n;

    // shadow state after reset: free list 0, 1, 2, ... wrapping
    for (i = 0; i < RING_SIZE; i++) begin
      link_tbl[i] = IDX_W'(i + 1);
      chained[i]  = 1'b0;
    end
    fl_head   = '0;
    free_cnt  = RING_SIZE;
    avail_idx = '0;
    used_idx  = '0;

    // directed table
    // first two sends take 0/1 and 2/3 from a fresh list
    directed.push_back(known_row(plain_row(KIND_SEND, '0, '0, 8'h00),
                                 ST_SENT, 8'd0, 8'd1, 8'd0, 9'd0, 9'd254));
    directed.push_back(known_row(plain_row(KIND_SEND, '1, '1, 8'hff),
                                 ST_SENT, 8'd2, 8'd3, 8'd1, 9'd0, 9'd252));
    directed.push_back(known_row(plain_row(KIND_CPL, 64'h0f0f_0f0f_0f0f_0f0f, 16'h0f0f, 8'd2),
                                 ST_DONE, 8'd2, 8'd0, 8'd0, 9'd2, 9'd254));
    directed.push_back(known_row(plain_row(KIND_CPL, '1, '1, 8'd0),
                                 ST_DONE, 8'd0, 8'd0, 8'd0, 9'd2, 9'd256));
    // freeing on a full ring saturates the count
    directed.push_back(known_row(plain_row(KIND_CPL, '0, '0, 8'hff),
                                 ST_DONE, 8'hff, 8'd0, 8'd0, 9'd1, 9'd256));
    directed.push_back(plain_row(KIND_SEND, 64'h5555_5555_5555_5555, 16'h5555, 8'h55));
    directed.push_back(plain_row(KIND_SEND, 64'haaaa_aaaa_aaaa_aaaa, 16'haaaa, 8'haa));
    // free a data descriptor alone, reuse it as a header: three-long chain
    directed.push_back(plain_row(KIND_CPL, 64'h0, 16'h0, 8'd2));
    directed.push_back(plain_row(KIND_SEND, 64'h0123_4567_89ab_cdef, 16'h1234, 8'h00));
    directed.push_back(plain_row(KIND_CPL, 64'h0, 16'h0, 8'd1));
    directed.push_back(plain_row(KIND_CPL, 64'h0, 16'h0, 8'hff));
    directed.push_back(plain_row(KIND_SEND, 64'h8000_0000_0000_0000, 16'h0001, 8'h80));
    directed.push_back(plain_row(KIND_CPL, 64'h1, 16'h8000, 8'hff));

    // reset held, then released on a falling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < directed.size(); i++) begin
      @(negedge clk_i);
      offer_word(directed[i].rq, directed[i].known, directed[i].res);
    end

    // random phases: none, sender idle, receiver stall (with hold-off), both
    for (ph = 0; ph < 4; ph++) begin
      // sender pauses until every result has come back
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk_i);
      if (ph == 0) busy_heads.delete();
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct <= 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct <= 45; end
        default: begin src_idle_pct = 22; sink_stall_pct <= 22; end
      endcase
      // long receiver hold-off while words keep coming, fills the block
      if (ph == 2) hold_requests <= hold_requests + 1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        @(negedge clk_i);
        offer_word(pick_random_request(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid  <= 1'b0;
    sink_stall_pct <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("virtqueue_tx_descriptor_manager verification clean");
    else
      $display("virtqueue_tx_descriptor_manager verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/vqtx_pkg.sv
design/vqtx_ctrl.sv
design/vqtx_dp.sv
design/virtqueue_tx_descriptor_manager.sv
design/vqtx_checker.sv
test/testbench.sv
